FILE: rtl/core/coefficient_divisibility_adjust_unit_assert.svh
// Assertion macros for the coefficient divisibility adjust unit
`ifndef COEFFICIENT_DIVISIBILITY_ADJUST_UNIT_ASSERT_SVH
`define COEFFICIENT_DIVISIBILITY_ADJUST_UNIT_ASSERT_SVH

// same-cycle implication
`define CDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cda_pkg.sv
// Package: types, constants and helpers of the coefficient divisibility adjust unit
`timescale 1ns / 1ps
package cda_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_POW_E       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POW_R       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIG_MODULUS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPLIT_RATIO = 2'd3;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [6:0]  STEPS_32  = 7'd32;
  localparam logic [6:0]  STEPS_64  = 7'd64;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_C,
    ST_MUL_C,
    ST_SUB_Z2,
    ST_START_D,
    ST_DIV_D,
    ST_START_K,
    ST_DIV_K,
    ST_MUL_AK,
    ST_CEIL,
    ST_MUL_UP,
    ST_MUL_VP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_START_CHK,
    ST_CHK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        start;
    logic [6:0]  steps;
    logic [30:0] divisor;
    logic [63:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
    logic [31:0] quo;
  } div_rsp_t;

  // floor residue from |x| mod m and sign of x, mapped to the symmetric interval
  function automatic logic signed [32:0] sym_res(input logic [31:0] rem, input logic neg,
                                                 input logic [30:0] m);
    logic [31:0] r;
    logic signed [32:0] rs;
    begin
      r = (neg && rem != 32'd0) ? ({1'b0, m} - rem) : rem;
      rs = $signed({1'b0, r});
      if (r > {2'b00, m[30:1]}) begin
        rs = rs - $signed({2'b00, m});
      end
      sym_res = rs;
    end
  endfunction

endpackage

FILE: rtl/core/cda_div.sv
// Restoring radix-2 divider shared by all remainder and quotient steps
`timescale 1ns / 1ps
module cda_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cda_pkg::div_req_t  req_i,
  output cda_pkg::div_rsp_t  rsp_o
);
  import cda_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [6:0]  cnt_q;
  logic [63:0] dv_q;
  logic [31:0] rem_q;
  logic [30:0] dsr_q;
  logic [31:0] trial;
  logic        fits;

  assign trial = {rem_q[30:0], dv_q[63]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dv_q  <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
      dv_q  <= {dv_q[62:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quo  = dv_q[31:0];

endmodule

FILE: rtl/core/coefficient_divisibility_adjust_unit.sv
// Top level: coefficient divisibility adjust unit
//
//   channel | signals                                         | direction
//   in      | in_valid_i/in_ready_o, coeff_in_i, last_in_i   | beat in
//   out     | out_valid_o/out_ready_i, coeff_out_o, u_mult_o, | beat out
//           | max_abs_u_o, not_divisible_o, last_out_o       |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                  | write only
//
// Split mode runs four divisions per beat and q-only mode two, all
// on the shared radix-2 divider; zero p^e skips the divider.
// in_ready_o is high only in idle.
// A finished beat waits in the output register; reset clears it and the running max.
`timescale 1ns / 1ps
`include "coefficient_divisibility_adjust_unit_assert.svh"
module coefficient_divisibility_adjust_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cda_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          coeff_in_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [62:0]          coeff_out_o,
  output logic signed [30:0]          u_mult_o,
  output logic [29:0]                 max_abs_u_o,
  output logic                        not_divisible_o,
  output logic                        last_out_o
);
  import cda_pkg::*;

  logic [30:0] pow_e_q, pow_r_q;
  logic [31:0] big_mod_q;
  logic [16:0] split_ratio_q;
  logic [16:0] alpha;

  state_e state_q, state_d;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [31:0] z_q;
  logic               last_q;
  logic               split_q;
  logic               bad_q;
  logic [63:0]        acc_q;
  logic signed [32:0] c_q;
  logic signed [31:0] k_q;
  logic signed [31:0] u_q;
  logic [31:0]        vp_hi_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic [29:0]        run_max_q;
  logic               out_valid_q;

  logic        in_acc;
  logic        out_free;
  logic        split_now;
  logic [63:0] acc_mag;
  logic [63:0] res_s64;
  logic [63:0] res_mag;
  logic [31:0] c_mag;
  logic [63:0] ceil_sum;
  logic signed [31:0] u_abs;
  logic [29:0] absu;
  logic [29:0] new_max;
  logic signed [32:0] v_val;

  cda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign alpha     = (split_ratio_q > ALPHA_ONE) ? ALPHA_ONE : split_ratio_q;
  assign split_now = (pow_r_q != 31'd0) && (pow_r_q < pow_e_q) && (alpha != 17'd0);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  assign acc_mag  = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign res_s64  = {acc_q[62], acc_q[62:0]};
  assign res_mag  = res_s64[63] ? (64'd0 - res_s64) : res_s64;
  assign c_mag    = c_q[32] ? 32'(33'd0 - c_q) : c_q[31:0];
  assign ceil_sum = prod_q[63:0] + 64'd65535;
  assign u_abs    = u_q[31] ? (32'sd0 - u_q) : u_q;
  assign absu     = u_abs[29:0];
  assign new_max  = (absu > run_max_q) ? absu : run_max_q;
  assign v_val    = {k_q[31], k_q} - {u_q[31], u_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_e_q       <= 31'd4;
      pow_r_q       <= 31'd2;
      big_mod_q     <= 32'd5;
      split_ratio_q <= 17'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POW_E:       pow_e_q       <= cfg_data_i[30:0];
        CFG_POW_R:       pow_r_q       <= cfg_data_i[30:0];
        CFG_BIG_MODULUS: big_mod_q     <= cfg_data_i;
        CFG_SPLIT_RATIO: split_ratio_q <= cfg_data_i[16:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      run_max_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        run_max_q   <= last_q ? 30'd0 : new_max;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.steps    = STEPS_32;
    div_req.divisor  = pow_e_q;
    div_req.dividend = '0;
    mul_a            = '0;
    mul_b            = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (pow_e_q == 31'd0) begin
            state_d = ST_FIN;
          end else begin
            div_req.start    = 1'b1;
            div_req.divisor  = split_now ? pow_r_q : pow_e_q;
            div_req.dividend = {(coeff_in_i[31] ? (32'd0 - coeff_in_i) : coeff_in_i), 32'd0};
            state_d          = ST_DIV_C;
          end
        end
      end
      ST_DIV_C:   if (div_rsp.done) state_d = ST_MUL_C;
      ST_MUL_C: begin
        mul_a   = c_q;
        mul_b   = {1'b0, big_mod_q};
        state_d = ST_SUB_Z2;
      end
      ST_SUB_Z2:  state_d = split_q ? ST_START_D : ST_START_CHK;
      ST_START_D: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_64;
        div_req.dividend = acc_mag;
        state_d          = ST_DIV_D;
      end
      ST_DIV_D:   if (div_rsp.done) state_d = ST_START_K;
      ST_START_K: begin
        div_req.start    = 1'b1;
        div_req.divisor  = pow_r_q;
        div_req.dividend = {c_mag, 32'd0};
        state_d          = ST_DIV_K;
      end
      ST_DIV_K:   if (div_rsp.done) state_d = ST_MUL_AK;
      ST_MUL_AK: begin
        mul_a   = {16'd0, alpha};
        mul_b   = {k_q[31], k_q};
        state_d = ST_CEIL;
      end
      ST_CEIL:    state_d = ST_MUL_UP;
      ST_MUL_UP: begin
        mul_a   = {u_q[31], u_q};
        mul_b   = {2'b00, pow_r_q};
        state_d = ST_MUL_VP;
      end
      ST_MUL_VP: begin
        mul_a   = v_val;
        mul_b   = {2'b00, pow_r_q};
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_a   = {1'b0, prod_q[31:0]};
        mul_b   = {1'b0, big_mod_q};
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mul_a   = {vp_hi_q[31], vp_hi_q};
        mul_b   = {1'b0, big_mod_q};
        state_d = ST_ADD_HI;
      end
      ST_ADD_HI:  state_d = ST_START_CHK;
      ST_START_CHK: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_64;
        div_req.dividend = res_mag;
        state_d          = ST_CHK;
      end
      ST_CHK:     if (div_rsp.done) state_d = ST_FIN;
      ST_FIN:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          z_q     <= coeff_in_i;
          last_q  <= last_in_i;
          split_q <= split_now;
          u_q     <= '0;
          bad_q   <= 1'b1;
          acc_q   <= {{32{coeff_in_i[31]}}, coeff_in_i};
        end
      end
      ST_DIV_C:  if (div_rsp.done)
        c_q <= sym_res(div_rsp.rem, z_q[31], split_q ? pow_r_q : pow_e_q);
      ST_SUB_Z2: acc_q <= {{32{z_q[31]}}, z_q} - prod_q[63:0];
      ST_DIV_D:  if (div_rsp.done) c_q <= sym_res(div_rsp.rem, acc_q[63], pow_e_q);
      ST_DIV_K:  if (div_rsp.done)
        k_q <= c_q[32] ? div_rsp.quo : (32'd0 - div_rsp.quo);
      ST_CEIL:   u_q <= ceil_sum[47:16];
      ST_MUL_VP: acc_q <= acc_q + prod_q[63:0];
      ST_MUL_LO: vp_hi_q <= prod_q[63:32];
      ST_MUL_HI: acc_q <= acc_q + prod_q[63:0];
      ST_ADD_HI: acc_q <= acc_q + {prod_q[31:0], 32'd0};
      ST_CHK:    if (div_rsp.done) bad_q <= (div_rsp.rem != 32'd0);
      default:   ;
    endcase
    if (state_q == ST_FIN && out_free) begin
      coeff_out_o     <= acc_q[62:0];
      u_mult_o        <= u_q[30:0];
      max_abs_u_o     <= new_max;
      not_divisible_o <= bad_q;
      last_out_o      <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `CDA_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE,
                  "accepted beat did not start work")
  `CDA_ASSERT_NXT(a_fin_loads_out, state_q == ST_FIN && out_free, out_valid_o,
                  "finished beat not presented")
  `CDA_ASSERT_NOW(a_div_done_waited, div_rsp.done,
                  state_q == ST_DIV_C || state_q == ST_DIV_D || state_q == ST_DIV_K ||
                  state_q == ST_CHK, "divider finished outside a wait state")
  `CDA_ASSERT_NOW(a_max_covers_u, out_valid_o,
                  max_abs_u_o >= (u_mult_o[30] ? 30'(31'd0 - u_mult_o) : u_mult_o[29:0]),
                  "running max below current u")

endmodule

FILE: sim/coefficient_divisibility_adjust_unit_tb.sv
// Testbench: checks the coefficient divisibility adjust unit against a cycle-free predictor
`timescale 1ns / 1ps
module coefficient_divisibility_adjust_unit_tb;
  import cda_pkg::*;

  typedef struct {
    logic [62:0] coeff;
    logic [30:0] u;
    logic [29:0] max_u;
    logic        bad;
    logic        last;
  } adj_result_t;

  class adjust_scoreboard;
    longint unsigned pe, pr, q, ratio, run_max;
    adj_result_t pending[$];
    int errors;

    function new();
      pe = 4; pr = 2; q = 5; ratio = 32768; run_max = 0; errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_POW_E:       pe = val[30:0];
        CFG_POW_R:       pr = val[30:0];
        CFG_BIG_MODULUS: q = val;
        CFG_SPLIT_RATIO: ratio = val[16:0];
        default: ;
      endcase
    endfunction

    function longint sym_mod(longint z, longint m);
      longint r;
      r = z % m;
      if (r < 0) r += m;
      if (r > m / 2) r -= m;
      return r;
    endfunction

    function void note_input(logic [31:0] zb, logic last);
      adj_result_t e;
      longint z, c, d, k, u, v, sres, alpha, ak;
      longint unsigned z2, res, absu;
      z = longint'($signed(zb));
      alpha = (ratio > 65536) ? 65536 : ratio;
      u = 0;
      if (pe == 0) begin
        res = z;
        e.bad = 1;
      end else begin
        if (pr != 0 && pr < pe && alpha > 0) begin
          c = sym_mod(z, pr);
          z2 = z - c * q;
          d = sym_mod(longint'(z2), pe);
          k = -(d / longint'(pr));
          ak = alpha * k;
          u = (ak >= 0) ? (ak + 65535) / 65536 : -((-ak) / 65536);
          v = k - u;
          res = z2 + u * pr + q * v * pr;
        end else begin
          c = sym_mod(z, pe);
          res = z - c * q;
        end
        res[63] = 1'b0;
        sres = res[62] ? longint'(res | 64'h8000_0000_0000_0000) : longint'(res);
        e.bad = (sres % longint'(pe)) != 0;
      end
      absu = (u < 0) ? -u : u;
      absu = absu & 64'h3FFF_FFFF;
      if (absu > run_max) run_max = absu;
      e.coeff = res[62:0];
      e.u = u[30:0];
      e.max_u = run_max[29:0];
      e.last = last;
      pending = {pending, e};
      if (last) run_max = 0;
    endfunction

    function void check_result(logic [62:0] co, logic [30:0] uo, logic [29:0] mo,
                               logic bo, logic lo);
      adj_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (co !== e.coeff) begin $error("coeff_out exp %h got %h", e.coeff, co); errors++; end
      if (uo !== e.u) begin $error("u_mult exp %h got %h", e.u, uo); errors++; end
      if (mo !== e.max_u) begin $error("max_abs_u exp %h got %h", e.max_u, mo); errors++; end
      if (bo !== e.bad) begin $error("not_divisible exp %b got %b", e.bad, bo); errors++; end
      if (lo !== e.last) begin $error("last_out exp %b got %b", e.last, lo); errors++; end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_POW_E;
  logic [31:0] cfg_data_i = 0;
  logic in_valid_i = 0, in_ready_o;
  logic signed [31:0] coeff_in_i = 0;
  logic last_in_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic signed [62:0] coeff_out_o;
  logic signed [30:0] u_mult_o;
  logic [29:0] max_abs_u_o;
  logic not_divisible_o, last_out_o;
  adjust_scoreboard sb = new();
  bit hold_rx = 0;
  longint cycles = 0;

  coefficient_divisibility_adjust_unit u_dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4_000_000) begin
      $display("FAIL coefficient_divisibility_adjust_unit");
      $finish;
    end
  end

  function int rand_gap();
    int s;
    s = $urandom_range(0, 99);
    if (s < 40) return 0;
    if (s < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // receiver: random stalls, plus a long hold while hold_rx is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(coeff_out_o, u_mult_o, max_abs_u_o, not_divisible_o, last_out_o);
      out_ready_i <= !hold_rx && ($urandom_range(0, 3) != 0);
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // valid stays high into the next beat when no gap follows
  task automatic send(logic [31:0] z, logic last, bit gaps);
    int g;
    coeff_in_i <= z; last_in_i <= last; in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(z, last);
    if (gaps) begin
      g = rand_gap();
      if (g != 0) begin
        in_valid_i <= 0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  function logic [31:0] rand_coeff();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 40) - 20;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_all(logic [31:0] e, logic [31:0] r, logic [31:0] q, logic [31:0] a);
    cfg_write(CFG_POW_E, e); cfg_write(CFG_POW_R, r);
    cfg_write(CFG_BIG_MODULUS, q); cfg_write(CFG_SPLIT_RATIO, a);
    cfg_we_i <= 0;
  endtask

  task automatic random_cfg();
    int p, ee, rr;
    logic [31:0] pe, pr;
    p = $urandom_range(2, 7);
    ee = $urandom_range(1, (p < 4) ? 12 : 6);
    rr = $urandom_range(1, ee);
    pe = 1; pr = 1;
    repeat (ee) pe = pe * p;
    repeat (rr) pr = pr * p;
    case ($urandom_range(0, 9))
      0: set_all(pe, pr, $urandom, $urandom_range(0, 131071));
      1: set_all(32'h4000_0000, 32'h0000_8000, 32'h8000_0001, $urandom_range(0, 65536));
      default: set_all(pe, pr, pe * $urandom_range(1, 20) + 1,
                       ($urandom_range(0, 3) == 0) ? 65536 : $urandom_range(0, 65536));
    endcase
  endtask

  initial begin
    logic [31:0] edges[6];
    int n;
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'hFFFF_FFFF, 2};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (edges[i]) send(edges[i], i == 5, 1);
    drain();
    set_all(0, 2, 5, 32768);
    send(32'h1234_5678, 0, 1); send(32'h8000_0000, 1, 1);
    drain();
    set_all(9, 0, 10, 200000);
    send(-7, 0, 1); send(32'h7FFF_FFFF, 1, 1);
    drain();
    set_all(27, 3, 28, 0);
    send(13, 0, 1); send(-13, 1, 1);
    drain();
    set_all(8, 3, 9, 65536);
    send(5, 0, 1); send(32'h8000_0001, 1, 1);
    drain();
    set_all(32'h4000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 131071);
    send(32'h7FFF_FFFF, 1, 1); send(32'h8000_0000, 0, 1);
    drain();
    set_all(25, 5, 26, 1);
    send(12, 0, 1); send(-12, 1, 1);
    drain();
    // long receiver hold while the sender keeps offering
    hold_rx = 1;
    fork
      begin repeat (600) @(posedge clk_i); hold_rx = 0; end
      repeat (8) send(rand_coeff(), $urandom_range(0, 3) == 0, 0);
    join
    drain();
    n = 0;
    while (n < 1720) begin
      random_cfg();
      repeat ($urandom_range(20, 60)) begin
        send(rand_coeff(), $urandom_range(0, 5) == 0, 1);
        n++;
      end
      drain();
    end
    if (sb.errors == 0)
      $display("PASS coefficient_divisibility_adjust_unit");
    else
      $display("FAIL coefficient_divisibility_adjust_unit");
    $finish;
  end
endmodule
